// ===== hdl/spk_pkg.sv =====
// Speck32/64 shared types, register indexes and round functions.
// No dependencies; used by every module of the cipher except spk_checker.
package spk_pkg;

    localparam int WORD_W  = 16;
    localparam int CFG_IDX_W = 8;
    localparam int ROT_A   = 7;
    localparam int ROT_B   = 2;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_WORD_0 = 8'd0,
        REG_KEY_WORD_1 = 8'd1,
        REG_KEY_WORD_2 = 8'd2,
        REG_KEY_WORD_3 = 8'd3
    } t_reg_idx;

    typedef enum logic {
        ACT_ENCRYPT = 1'b0,
        ACT_DECRYPT = 1'b1
    } t_action;

    typedef struct packed {
        t_word x;
        t_word y;
    } t_pair;

    typedef struct packed {
        t_action action;
        t_word   x;
        t_word   y;
    } t_blk;

    function automatic t_word rotr(input t_word v, input int s);
        rotr = (v >> s) | (v << (WORD_W - s));
    endfunction

    function automatic t_word rotl(input t_word v, input int s);
        rotl = (v << s) | (v >> (WORD_W - s));
    endfunction

    function automatic t_pair fwd_round(input t_word x, input t_word y, input t_word k);
        t_word nx;
        t_word ny;
        nx = (rotr(x, ROT_A) + y) ^ k;
        ny = rotl(y, ROT_B) ^ nx;
        fwd_round.x = nx;
        fwd_round.y = ny;
    endfunction

    function automatic t_pair inv_round(input t_word x, input t_word y, input t_word k);
        t_word nx;
        t_word ny;
        ny = rotr(y ^ x, ROT_B);
        nx = rotl((x ^ k) - ny, ROT_A);
        inv_round.x = nx;
        inv_round.y = ny;
    endfunction

endpackage

// ===== hdl/spk_key_sched.sv =====
// Speck32/64 key registers and round key expansion, one round per cycle.
// Depends on spk_pkg.
module spk_key_sched #(
    parameter int ROUNDS = 22
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [spk_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  spk_pkg::t_word                i_cfg_data,
    output spk_pkg::t_word                o_rk [ROUNDS],
    output logic                          o_keys_ready
);
    import spk_pkg::*;

    localparam int CW = $clog2(ROUNDS + 1);

    t_word         r_key0, r_key1, r_key2, r_key3;
    t_word         r_k, r_l0, r_l1, r_l2;
    t_word         r_rk [ROUNDS];
    logic [CW-1:0] r_rnd;
    logic          r_busy;
    logic          r_load;
    t_pair         n_step;

    assign n_step = fwd_round(r_l0, r_k, WORD_W'(r_rnd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0;
            r_key1 <= '0;
            r_key2 <= '0;
            r_key3 <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_KEY_WORD_0: r_key0 <= i_cfg_data;
                REG_KEY_WORD_1: r_key1 <= i_cfg_data;
                REG_KEY_WORD_2: r_key2 <= i_cfg_data;
                REG_KEY_WORD_3: r_key3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_load <= 1'b1;
            r_rnd  <= '0;
        end else if (i_cfg_valid) begin
            r_busy <= 1'b1;
            r_load <= 1'b1;
        end else if (r_load) begin
            r_load <= 1'b0;
            r_rnd  <= '0;
        end else if (r_busy) begin
            r_rnd <= r_rnd + CW'(1);
            if (r_rnd == CW'(ROUNDS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_load) begin
            r_k  <= r_key0;
            r_l0 <= r_key1;
            r_l1 <= r_key2;
            r_l2 <= r_key3;
        end else if (r_busy) begin
            r_k  <= n_step.y;
            r_l0 <= r_l1;
            r_l1 <= r_l2;
            r_l2 <= n_step.x;
            for (int j = 0; j < ROUNDS - 1; j++) begin
                r_rk[j] <= r_rk[j+1];
            end
            r_rk[ROUNDS-1] <= r_k;
        end
    end

    assign o_rk         = r_rk;
    assign o_keys_ready = !r_busy;

endmodule

// ===== hdl/spk_round_stage.sv =====
// One registered Speck32/64 round, forward or inverse per item, with handshake.
// Depends on spk_pkg.
module spk_round_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  spk_pkg::t_blk  i_data,
    input  spk_pkg::t_word i_key_enc,
    input  spk_pkg::t_word i_key_dec,
    output logic           o_valid,
    input  logic           i_ready,
    output spk_pkg::t_blk  o_data
);
    import spk_pkg::*;

    logic  r_valid;
    t_blk  r_data;
    t_pair n_pair;

    always_comb begin
        if (i_data.action == ACT_DECRYPT) begin
            n_pair = inv_round(i_data.x, i_data.y, i_key_dec);
        end else begin
            n_pair = fwd_round(i_data.x, i_data.y, i_key_enc);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data.action <= i_data.action;
            r_data.x      <= n_pair.x;
            r_data.y      <= n_pair.y;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hdl/speck_32_64_block_cipher.sv =====
// Speck32/64 block cipher top level: key schedule plus an unrolled round pipeline.
// Depends on spk_pkg, spk_key_sched and spk_round_stage.
//
// One block per clock while the keys are ready and the output is not stalled, ROUNDS + 0
// register stages deep, one round per stage, the last stage being the output register.
// Stalls on the output fill bubbles upstream before the input stops. Round keys are
// expanded into registers by a one-round-per-cycle unit; after reset and after each key
// write the input is held off while the keys are expanded.
module speck_32_64_block_cipher #(
    parameter int ROUNDS = 22
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,  // block_low, block_high
    input  logic [0:0]                    s_axis_tuser,  // action
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,  // result_low, result_high
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [spk_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);
    import spk_pkg::*;

    t_word rk [ROUNDS];
    logic  keys_ready;
    logic  stg_valid [ROUNDS+1];
    logic  stg_ready [ROUNDS+1];
    t_blk  stg_data  [ROUNDS+1];

    assign o_cfg_ready = 1'b1;

    spk_key_sched #(.ROUNDS(ROUNDS)) u_key_sched (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_rk         (rk),
        .o_keys_ready (keys_ready)
    );

    assign stg_valid[0]       = s_axis_tvalid && keys_ready;
    assign s_axis_tready      = stg_ready[0] && keys_ready;
    assign stg_data[0].action = t_action'(s_axis_tuser[0]);
    assign stg_data[0].y      = s_axis_tdata[15:0];
    assign stg_data[0].x      = s_axis_tdata[31:16];

    for (genvar s = 0; s < ROUNDS; s++) begin : g_round
        spk_round_stage u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (stg_valid[s]),
            .o_ready   (stg_ready[s]),
            .i_data    (stg_data[s]),
            .i_key_enc (rk[s]),
            .i_key_dec (rk[ROUNDS-1-s]),
            .o_valid   (stg_valid[s+1]),
            .i_ready   (stg_ready[s+1]),
            .o_data    (stg_data[s+1])
        );
    end

    assign stg_ready[ROUNDS] = m_axis_tready;
    assign m_axis_tvalid     = stg_valid[ROUNDS];
    assign m_axis_tdata      = {stg_data[ROUNDS].x, stg_data[ROUNDS].y};

endmodule

// ===== hdl/spk_checker.sv =====
// Port-level checks for the Speck32/64 cipher, bound to the top level.
// Depends on speck_32_64_block_cipher ports only.
module spk_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_reset_holds_input: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input taken before key expansion after reset");

    a_cfg_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> !s_axis_tready)
        else $error("input taken during key expansion");

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown right after reset");

endmodule

bind speck_32_64_block_cipher spk_checker u_spk_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready)
);

// ===== tb/sv/tb_speck_32_64_block_cipher_chk.sv =====
// Checker for speck_32_64_block_cipher: follows key writes, predicts every block transaction
// and compares the result stream field by field. Depends on spk_pkg for types and codes.
module tb_speck_32_64_block_cipher_chk #(
    parameter int ROUNDS = 22
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,  // block_low, block_high
    input  logic [0:0]                    s_axis_tuser,  // action
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [31:0]                   m_axis_tdata,  // result_low, result_high
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [spk_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import spk_pkg::*;

    typedef struct {
        t_word lo;
        t_word hi;
    } t_block_words;

    t_word        key_words[4];
    t_block_words expected_blocks[$];

    function automatic t_word ror16(t_word v, int s);
        return (v >> s) | (v << (16 - s));
    endfunction

    function automatic t_word rol16(t_word v, int s);
        return (v << s) | (v >> (16 - s));
    endfunction

    function automatic t_block_words speck_transform(t_action act, t_block_words blk);
        t_word        sched[3];
        t_word        rk[ROUNDS];
        t_word        k;
        t_word        x;
        t_word        y;
        t_block_words res;
        k        = key_words[0];
        sched[0] = key_words[1];
        sched[1] = key_words[2];
        sched[2] = key_words[3];
        for (int i = 0; i < ROUNDS; i++) begin
            rk[i]        = k;
            sched[i % 3] = (ror16(sched[i % 3], 7) + k) ^ t_word'(i);
            k            = rol16(k, 2) ^ sched[i % 3];
        end
        x = blk.hi;
        y = blk.lo;
        if (act == ACT_ENCRYPT) begin
            for (int i = 0; i < ROUNDS; i++) begin
                x = (ror16(x, 7) + y) ^ rk[i];
                y = rol16(y, 2) ^ x;
            end
        end else begin
            for (int i = ROUNDS - 1; i >= 0; i--) begin
                y = ror16(y ^ x, 2);
                x = rol16((x ^ rk[i]) - y, 7);
            end
        end
        res.lo = y;
        res.hi = x;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_block_words got;
        t_block_words want;
        t_block_words blk;
        if (!i_rst_n) begin
            foreach (key_words[i]) key_words[i] = '0;
            expected_blocks.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_KEY_WORD_0: key_words[0] = i_cfg_data;
                    REG_KEY_WORD_1: key_words[1] = i_cfg_data;
                    REG_KEY_WORD_2: key_words[2] = i_cfg_data;
                    REG_KEY_WORD_3: key_words[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.lo = m_axis_tdata[15:0];
                got.hi = m_axis_tdata[31:16];
                if (expected_blocks.size() == 0) begin
                    $display("%0t: result with none expected, actual %h", $time, m_axis_tdata);
                    o_fail_count++;
                end else begin
                    want = expected_blocks.pop_front();
                    if (got.lo !== want.lo) begin
                        $display("%0t: result_low expected %h actual %h", $time, want.lo, got.lo);
                        o_fail_count++;
                    end
                    if (got.hi !== want.hi) begin
                        $display("%0t: result_high expected %h actual %h", $time, want.hi, got.hi);
                        o_fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                blk.lo = s_axis_tdata[15:0];
                blk.hi = s_axis_tdata[31:16];
                expected_blocks.push_back(speck_transform(t_action'(s_axis_tuser[0]), blk));
            end
        end
        o_pending = expected_blocks.size();
    end

endmodule

// ===== tb/sv/tb_speck_32_64_block_cipher.sv =====
// Top of the speck_32_64_block_cipher testbench: clock, reset, key writes and block stimulus.
// Depends on spk_pkg, the cipher RTL and tb_speck_32_64_block_cipher_chk.
module tb_speck_32_64_block_cipher;
    timeunit 1ns;
    timeprecision 1ps;

    import spk_pkg::*;

    localparam int ROUNDS      = 22;
    localparam int STALL_LIMIT = 2000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata;
    logic [0:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [31:0]          m_axis_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;

    int fail_count;
    int pending;
    int stall_left  = 0;
    int idle_cycles = 0;
    bit quiet_tail  = 1'b0;

    t_word corner_words[6] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'h5555, 16'hAAAA};

    speck_32_64_block_cipher #(.ROUNDS(ROUNDS)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    tb_speck_32_64_block_cipher_chk #(.ROUNDS(ROUNDS)) u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // output backpressure in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet_tail) begin
            m_axis_tready <= 1'b1;
            stall_left    <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) begin
                m_axis_tready <= 1'b1;
            end
        end else if ($urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(1, 11);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_speck_32_64_block_cipher: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_block(t_action act, t_word lo, t_word hi);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hi, lo};
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, t_word val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // junk goes to an unmapped index and must leave the key alone
    task automatic load_key(t_word k0, t_word k1, t_word k2, t_word k3,
                            logic [CFG_IDX_W-1:0] junk_idx);
        write_reg(REG_KEY_WORD_0, k0);
        write_reg(junk_idx, t_word'($urandom));
        write_reg(REG_KEY_WORD_1, k1);
        write_reg(REG_KEY_WORD_2, k2);
        write_reg(REG_KEY_WORD_3, k3);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // advance the clock first so the pending count includes the last accepted transaction
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    function automatic t_word pick_word();
        if ($urandom_range(0, 7) == 0) begin
            return corner_words[$urandom_range(0, 5)];
        end
        return t_word'($urandom);
    endfunction

    function automatic t_word pick_key_word();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return t_word'($urandom);
        endcase
    endfunction

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_ENCRYPT;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_KEY_WORD_0;
        i_cfg_data    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all-zero key from reset
        for (int i = 0; i < 6; i++) begin
            push_block(ACT_ENCRYPT, corner_words[i], corner_words[5 - i]);
            push_block(ACT_DECRYPT, corner_words[i], corner_words[i]);
        end
        drain();

        // published test vector, both directions
        load_key(16'h0100, 16'h0908, 16'h1110, 16'h1918, 8'hFF);
        push_block(ACT_ENCRYPT, 16'h694C, 16'h6574);
        push_block(ACT_DECRYPT, 16'h42F2, 16'hA868);
        drain();

        load_key(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h04);
        push_block(ACT_ENCRYPT, 16'hFFFF, 16'hFFFF);
        push_block(ACT_DECRYPT, 16'h0000, 16'h0000);
        drain();

        load_key(16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h80);
        push_block(ACT_ENCRYPT, 16'h0000, 16'h0000);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            load_key(pick_key_word(), pick_key_word(), pick_key_word(), pick_key_word(),
                     CFG_IDX_W'($urandom_range(4, 255)));
            if (ph == 9) begin
                quiet_tail = 1'b1;
            end
            for (int n = 0; n < 65; n++) begin
                push_block(t_action'($urandom_range(0, 1)), pick_word(), pick_word());
            end
            drain();
        end

        repeat (ROUNDS + 4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_speck_32_64_block_cipher: PASS");
        end else begin
            $display("tb_speck_32_64_block_cipher: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/spk_pkg.sv
hdl/spk_key_sched.sv
hdl/spk_round_stage.sv
hdl/speck_32_64_block_cipher.sv
hdl/spk_checker.sv
tb/sv/tb_speck_32_64_block_cipher_chk.sv
tb/sv/tb_speck_32_64_block_cipher.sv
